>>> rtl/mde_pkg.sv
// shared constants and types for the energy accumulator
`default_nettype none

package mde_pkg;

   localparam int LANES           = 4;
   localparam int NUM_DOMAINS_DEF = 4;
   localparam int DRAM_LANE       = 3;
   localparam int RAW_W           = 32;
   localparam int ACC_W           = 64;
   localparam int SCALE_W         = 20;
   localparam int PROD_LO_W       = RAW_W + SCALE_W;
   localparam int SHIFT_W         = 5;
   localparam int MASK_W          = 4;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 5;

   localparam logic [SCALE_W-1:0] SCALE_FACTOR = SCALE_W'(1000000);

   localparam logic [CSR_IDX_W-1:0] CSR_MASK       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_SHIFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAM_SHIFT = 2'd2;

   localparam logic [MASK_W-1:0]  MASK_RESET       = 4'd13;
   localparam logic [SHIFT_W-1:0] UNIT_SHIFT_RESET = 5'd14;
   localparam logic [SHIFT_W-1:0] DRAM_SHIFT_RESET = 5'd16;

   typedef enum logic [2:0] {
      OP_PRIME    = 3'd0,
      OP_ACCUM    = 3'd1,
      OP_READ     = 3'd2,
      OP_READ_CLR = 3'd3,
      OP_CLEAR    = 3'd4
   } mde_op_type;

   typedef struct packed {
      logic prime;
      logic accum;
      logic clear;
      logic load_prod;
      logic load_sum;
   } mde_lane_ctl_type;

endpackage

`default_nettype wire

>>> rtl/mde_lane.sv
// one domain lane: stored reading, accumulator and scaling products
`default_nettype none

module mde_lane
   import mde_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mde_lane_ctl_type ctl,
   input  wire logic             lane_en,
   input  wire logic [RAW_W-1:0] raw,
   output logic      [ACC_W-1:0] sum
);

   logic [RAW_W-1:0]     last_ff, last_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [PROD_LO_W-1:0] prod_lo_ff, prod_lo_in;
   logic [RAW_W-1:0]     prod_hi_ff, prod_hi_in;
   logic [ACC_W-1:0]     sum_ff, sum_in;
   logic [RAW_W-1:0]     delta;
   logic [PROD_LO_W-1:0] prod_hi_full;

   assign delta = raw - last_ff;

   always_comb begin
      last_in = last_ff;
      acc_in  = acc_ff;
      if ((ctl.prime || ctl.accum) && lane_en) begin
         last_in = raw;
         if (ctl.accum) begin
            acc_in = acc_ff + {{(ACC_W-RAW_W){1'b0}}, delta};
         end
      end
      if (ctl.clear) begin
         acc_in = '0;
      end
   end

   // acc * scale mod 2^64 from two 32 x 20 products
   assign prod_lo_in   = PROD_LO_W'(acc_ff[RAW_W-1:0]) * PROD_LO_W'(SCALE_FACTOR);
   assign prod_hi_full = PROD_LO_W'(acc_ff[ACC_W-1:RAW_W]) * PROD_LO_W'(SCALE_FACTOR);
   assign prod_hi_in   = prod_hi_full[RAW_W-1:0];
   assign sum_in       = {prod_hi_ff, {RAW_W{1'b0}}}
                       + {{(ACC_W-PROD_LO_W){1'b0}}, prod_lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         acc_ff  <= '0;
      end else begin
         last_ff <= last_in;
         acc_ff  <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
      if (ctl.load_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

>>> rtl/mde_merge.sv
// output stage: per-lane shift, disable gating and result register
`default_nettype none

module mde_merge
   import mde_pkg::*;
(
   input  wire logic                            clock,
   input  wire logic                            load,
   input  wire logic [LANES-1:0]                lane_en,
   input  wire logic [SHIFT_W-1:0]              unit_shift,
   input  wire logic [SHIFT_W-1:0]              dram_shift,
   input  wire logic [LANES-1:0][ACC_W-1:0]     sums,
   output logic      [LANES-1:0][ACC_W-1:0]     energy
);

   logic [LANES-1:0][ACC_W-1:0] energy_ff, energy_in;

   always_comb begin
      for (int d = 0; d < LANES; d++) begin
         if (!lane_en[d]) begin
            energy_in[d] = '0;
         end else if (d == DRAM_LANE) begin
            energy_in[d] = sums[d] >> dram_shift;
         end else begin
            energy_in[d] = sums[d] >> unit_shift;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         energy_ff <= energy_in;
      end
   end

   assign energy = energy_ff;

endmodule

`default_nettype wire

>>> rtl/multi_domain_energy_accumulator.sv
// top level: four-domain wraparound energy counter accumulator
//
//   channel   ports                               direction
//   request   req_valid/req_ready, op, raw_*      in
//   response  rsp_valid/rsp_ready, energy_*       out
//   csr       csr_valid/csr_ready, index, data    in
//
// one transfer per cycle unless stalled; ops without a result take effect at the transfer
// read ops raise rsp_valid once through the product, sum and shift registers
// the stall chain runs from rsp_ready through the three stage valids to req_ready
// synchronous reset clears readings, accumulators and stage valids, restores csr defaults
// csr writes are always taken (csr_ready high)
`default_nettype none

module multi_domain_energy_accumulator
   import mde_pkg::*;
#(
   parameter int NUM_DOMAINS = NUM_DOMAINS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            req_op,
   input  wire logic [RAW_W-1:0]      req_raw_core,
   input  wire logic [RAW_W-1:0]      req_raw_plane,
   input  wire logic [RAW_W-1:0]      req_raw_package,
   input  wire logic [RAW_W-1:0]      req_raw_dram,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [ACC_W-1:0]      rsp_energy_core,
   output logic      [ACC_W-1:0]      rsp_energy_plane,
   output logic      [ACC_W-1:0]      rsp_energy_package,
   output logic      [ACC_W-1:0]      rsp_energy_dram,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [SHIFT_W-1:0] unit_sh_ff, unit_sh_in;
   logic [SHIFT_W-1:0] dram_sh_ff, dram_sh_in;
   logic               s1_v_ff, s1_v_in;
   logic               s2_v_ff, s2_v_in;
   logic               s3_v_ff, s3_v_in;
   logic               en1, en2, en3;
   logic               accept, is_read, csr_wr;
   mde_lane_ctl_type   ctl;
   logic [LANES-1:0]              lane_en;
   logic [LANES-1:0][RAW_W-1:0]   raw;
   logic [LANES-1:0][ACC_W-1:0]   sums;
   logic [LANES-1:0][ACC_W-1:0]   energy;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      mask_in    = mask_ff;
      unit_sh_in = unit_sh_ff;
      dram_sh_in = dram_sh_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_MASK:       mask_in    = csr_data[MASK_W-1:0];
            CSR_UNIT_SHIFT: unit_sh_in = csr_data[SHIFT_W-1:0];
            CSR_DRAM_SHIFT: dram_sh_in = csr_data[SHIFT_W-1:0];
            default:        mask_in    = mask_ff;
         endcase
      end
   end

   // elastic three-stage pipe for read results
   assign en3       = !s3_v_ff || rsp_ready;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req_ready = en1;
   assign accept    = req_valid && req_ready;
   assign is_read   = (req_op == OP_READ) || (req_op == OP_READ_CLR);

   assign s1_v_in = en1 ? (accept && is_read) : s1_v_ff;
   assign s2_v_in = en2 ? s1_v_ff : s2_v_ff;
   assign s3_v_in = en3 ? s2_v_ff : s3_v_ff;

   assign ctl.prime     = accept && (req_op == OP_PRIME);
   assign ctl.accum     = accept && (req_op == OP_ACCUM);
   assign ctl.clear     = accept && ((req_op == OP_READ_CLR) || (req_op == OP_CLEAR));
   assign ctl.load_prod = accept && is_read;
   assign ctl.load_sum  = en2 && s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= MASK_RESET;
         unit_sh_ff <= UNIT_SHIFT_RESET;
         dram_sh_ff <= DRAM_SHIFT_RESET;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
      end else begin
         mask_ff    <= mask_in;
         unit_sh_ff <= unit_sh_in;
         dram_sh_ff <= dram_sh_in;
         s1_v_ff    <= s1_v_in;
         s2_v_ff    <= s2_v_in;
         s3_v_ff    <= s3_v_in;
      end
   end

   assign raw[0] = req_raw_core;
   assign raw[1] = req_raw_plane;
   assign raw[2] = req_raw_package;
   assign raw[3] = req_raw_dram;

   for (genvar d = 0; d < LANES; d++) begin : g_lane
      if (d < NUM_DOMAINS) begin : g_on
         assign lane_en[d] = mask_ff[d];
         mde_lane u_lane (
            .clock   (clock),
            .reset   (reset),
            .ctl     (ctl),
            .lane_en (lane_en[d]),
            .raw     (raw[d]),
            .sum     (sums[d])
         );
      end else begin : g_off
         assign lane_en[d] = 1'b0;
         assign sums[d]    = '0;
      end
   end

   mde_merge u_merge (
      .clock      (clock),
      .load       (en3 && s2_v_ff),
      .lane_en    (lane_en),
      .unit_shift (unit_sh_ff),
      .dram_shift (dram_sh_ff),
      .sums       (sums),
      .energy     (energy)
   );

   assign rsp_valid          = s3_v_ff;
   assign rsp_energy_core    = energy[0];
   assign rsp_energy_plane   = energy[1];
   assign rsp_energy_package = energy[2];
   assign rsp_energy_dram    = energy[3];

endmodule

`default_nettype wire

>>> rtl/mde_checker.sv
// port-level checks for the energy accumulator, bound to the top level
`default_nettype none

module mde_checker
   import mde_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [ACC_W-1:0]      rsp_energy_core,
   input  wire logic [ACC_W-1:0]      rsp_energy_dram,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [MASK_W-1:0] mask_ff, mask_in;

   // shadow of the enable mask from csr transfers
   assign mask_in = (csr_valid && csr_ready && (csr_index == CSR_MASK))
                  ? csr_data[MASK_W-1:0] : mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else begin
         mask_ff <= mask_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_energy_core))
      else $error("stalled result changed");

   // result register loaded at the previous edge
   a_core_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(!rsp_valid || rsp_ready) && !$past(mask_ff[0])
      |-> rsp_energy_core == '0)
      else $error("disabled core domain gave nonzero energy");

   a_dram_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(!rsp_valid || rsp_ready) && !$past(mask_ff[DRAM_LANE])
      |-> rsp_energy_dram == '0)
      else $error("disabled dram domain gave nonzero energy");

endmodule

bind multi_domain_energy_accumulator mde_checker u_mde_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_energy_core (rsp_energy_core),
   .rsp_energy_dram (rsp_energy_dram),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready),
   .csr_index       (csr_index),
   .csr_data        (csr_data)
);

`default_nettype wire

>>> test/multi_domain_energy_accumulator_tb.sv
// testbench for the four-domain energy accumulator: predicted readouts checked against the block
`timescale 1ns / 100ps

module multi_domain_energy_accumulator_tb
   import mde_pkg::*;
;

   localparam int LIMIT_CYCLES = 600000;
   localparam int PIPE_LATENCY = 3;
   localparam int MAX_WAIT     = 14;
   localparam int SHOWN_ERRORS = 10;

   localparam logic [ACC_W-1:0]     MICRO_SCALE    = 64'd1000000;
   localparam logic [2:0]           OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0]           OP_SPARE_LAST  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE      = 2'd3;

   typedef struct packed {
      logic [ACC_W-1:0] core_uj;
      logic [ACC_W-1:0] plane_uj;
      logic [ACC_W-1:0] pkg_uj;
      logic [ACC_W-1:0] dram_uj;
   } energy_set_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [2:0]            req_op;
   logic [RAW_W-1:0]      req_raw_core;
   logic [RAW_W-1:0]      req_raw_plane;
   logic [RAW_W-1:0]      req_raw_package;
   logic [RAW_W-1:0]      req_raw_dram;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [ACC_W-1:0]      rsp_energy_core;
   logic [ACC_W-1:0]      rsp_energy_plane;
   logic [ACC_W-1:0]      rsp_energy_package;
   logic [ACC_W-1:0]      rsp_energy_dram;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   energy_set_type       expected_energy_q[$];
   logic [RAW_W-1:0]     last_count [LANES];
   logic [ACC_W-1:0]     energy_total [LANES];
   logic [MASK_W-1:0]    model_mask;
   logic [SHIFT_W-1:0]   model_unit_shift;
   logic [SHIFT_W-1:0]   model_dram_shift;
   logic [RAW_W-1:0]     meter [LANES];
   int                   error_count = 0;
   int                   cycle_count = 0;
   bit                   stalls_on = 1'b1;

   multi_domain_energy_accumulator uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_raw_core       (req_raw_core),
      .req_raw_plane      (req_raw_plane),
      .req_raw_package    (req_raw_package),
      .req_raw_dram       (req_raw_dram),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_energy_core    (rsp_energy_core),
      .rsp_energy_plane   (rsp_energy_plane),
      .rsp_energy_package (rsp_energy_package),
      .rsp_energy_dram    (rsp_energy_dram),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic void clear_totals();
      for (int d = 0; d < LANES; d++) begin
         energy_total[d] = '0;
      end
   endfunction

   function automatic logic [ACC_W-1:0] scaled_energy(input int lane);
      logic [ACC_W-1:0] product;
      if (!model_mask[lane]) begin
         return '0;
      end
      product = energy_total[lane] * MICRO_SCALE;
      return product >> ((lane == DRAM_LANE) ? model_dram_shift : model_unit_shift);
   endfunction

   function automatic void predict_energy(input logic [2:0] op,
                                          input logic [RAW_W-1:0] rc, rp, rk, rd);
      logic [RAW_W-1:0] now [LANES];
      energy_set_type   readout;
      now[0] = rc;
      now[1] = rp;
      now[2] = rk;
      now[3] = rd;
      if (op == OP_PRIME || op == OP_ACCUM) begin
         for (int d = 0; d < LANES; d++) begin
            if (model_mask[d]) begin
               if (op == OP_ACCUM) begin
                  energy_total[d] = energy_total[d] + {32'd0, now[d] - last_count[d]};
               end
               last_count[d] = now[d];
            end
         end
      end else if (op == OP_READ || op == OP_READ_CLR) begin
         readout.core_uj  = scaled_energy(0);
         readout.plane_uj = scaled_energy(1);
         readout.pkg_uj   = scaled_energy(2);
         readout.dram_uj  = scaled_energy(DRAM_LANE);
         expected_energy_q.push_back(readout);
         if (op == OP_READ_CLR) begin
            clear_totals();
         end
      end else if (op == OP_CLEAR) begin
         clear_totals();
      end
   endfunction

   function automatic void check_field(input string name, input logic [ACC_W-1:0] want, got);
      if (want !== got) begin
         error_count++;
         if (error_count <= SHOWN_ERRORS) begin
            $display("mismatch %s: expected %h got %h", name, want, got);
         end
      end
   endfunction

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      energy_set_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_energy_q.size() == 0) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS) begin
               $display("unexpected result: core %h plane %h package %h dram %h",
                        rsp_energy_core, rsp_energy_plane, rsp_energy_package,
                        rsp_energy_dram);
            end
         end else begin
            want = expected_energy_q.pop_front();
            check_field("core", want.core_uj, rsp_energy_core);
            check_field("plane", want.plane_uj, rsp_energy_plane);
            check_field("package", want.pkg_uj, rsp_energy_package);
            check_field("dram", want.dram_uj, rsp_energy_dram);
         end
      end
   end

   // result side back-pressure
   initial begin : response_side
      int hold;
      rsp_ready = 1'b0;
      forever begin
         hold = stalls_on ? $urandom_range(MAX_WAIT, 0) : 0;
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [RAW_W-1:0] rc, rp, rk, rd);
      int gap;
      gap = stalls_on ? $urandom_range(MAX_WAIT, 0) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_raw_core    <= rc;
      req_raw_plane   <= rp;
      req_raw_package <= rk;
      req_raw_dram    <= rd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_energy(op, rc, rp, rk, rd);
   endtask

   task automatic send_readout(input logic [2:0] op);
      send_item(op, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_energy_q.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MASK:       model_mask       = data[MASK_W-1:0];
         CSR_UNIT_SHIFT: model_unit_shift = data[SHIFT_W-1:0];
         CSR_DRAM_SHIFT: model_dram_shift = data[SHIFT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SHIFT_W-1:0] pick_shift();
      case ($urandom_range(3, 0))
         0:       return '0;
         1:       return '1;
         default: return SHIFT_W'($urandom);
      endcase
   endfunction

   task automatic random_settings();
      write_csr(CSR_MASK, CSR_DATA_W'($urandom));
      write_csr(CSR_UNIT_SHIFT, pick_shift());
      write_csr(CSR_DRAM_SHIFT, pick_shift());
   endtask

   task automatic test_directed_ops();
      // reset settings: plane disabled, the other three enabled
      send_item(OP_PRIME, '0, '0, '0, '0);
      send_item(OP_ACCUM, '1, '1, '1, '1);
      send_readout(OP_READ);
      // counter wrap from all ones down to four
      send_item(OP_ACCUM, 32'd4, 32'd4, 32'd4, 32'd4);
      send_readout(OP_READ_CLR);
      send_readout(OP_READ);
      for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
         send_readout(3'(c));
      end
      send_item(OP_ACCUM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_readout(OP_READ);
      send_readout(OP_CLEAR);
      send_readout(OP_READ);
   endtask

   task automatic test_csr_extremes();
      wait_for_idle();
      write_csr(CSR_MASK, '1);
      write_csr(CSR_UNIT_SHIFT, '0);
      write_csr(CSR_DRAM_SHIFT, '0);
      send_readout(OP_PRIME);
      send_readout(OP_ACCUM);
      send_readout(OP_READ);
      wait_for_idle();
      write_csr(CSR_UNIT_SHIFT, '1);
      write_csr(CSR_DRAM_SHIFT, '1);
      send_readout(OP_READ);
      wait_for_idle();
      write_csr(CSR_MASK, '0);
      send_readout(OP_READ);
      send_readout(OP_ACCUM);
      wait_for_idle();
      write_csr(CSR_MASK, CSR_DATA_W'(4'hf));
      write_csr(CSR_UNIT_SHIFT, CSR_DATA_W'(3));
      send_readout(OP_READ);
      wait_for_idle();
      write_csr(CSR_SPARE, '1);
      send_readout(OP_READ_CLR);
   endtask

   // full-range deltas drive the accumulators well past 32 bits
   task automatic test_scale_overflow();
      logic [RAW_W-1:0] reading;
      wait_for_idle();
      write_csr(CSR_MASK, CSR_DATA_W'(4'hf));
      write_csr(CSR_UNIT_SHIFT, '0);
      write_csr(CSR_DRAM_SHIFT, pick_shift());
      stalls_on = 1'b0;
      reading = '0;
      send_item(OP_PRIME, reading, reading, reading, reading);
      for (int k = 1; k <= 500; k++) begin
         reading = reading - 1'b1;
         send_item(OP_ACCUM, reading, reading, reading, reading);
         if (k % 100 == 0) begin
            send_readout(OP_READ);
         end
      end
      send_readout(OP_READ_CLR);
      wait_for_idle();
      stalls_on = 1'b1;
   endtask

   task automatic random_item();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 58) begin
         for (int d = 0; d < LANES; d++) begin
            if ($urandom_range(9, 0) == 0) begin
               meter[d] = meter[d] + $urandom;
            end else begin
               meter[d] = meter[d] + $urandom_range(1 << 20, 0);
            end
         end
         send_item((roll < 50) ? OP_ACCUM : OP_PRIME, meter[0], meter[1], meter[2], meter[3]);
      end else if (roll < 73) begin
         send_readout(OP_READ);
      end else if (roll < 81) begin
         send_readout(OP_READ_CLR);
      end else if (roll < 86) begin
         send_readout(OP_CLEAR);
      end else if (roll < 91) begin
         send_readout(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)));
      end else begin
         // readings unrelated to the running counters
         send_readout(OP_ACCUM);
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         wait_for_idle();
         random_settings();
         stalls_on = ($urandom_range(3, 0) != 0);
         for (int d = 0; d < LANES; d++) begin
            meter[d] = $urandom;
         end
         send_item(OP_PRIME, meter[0], meter[1], meter[2], meter[3]);
         for (int k = 0; k < 100; k++) begin
            if (k == 50 && phase % 4 == 1) begin
               wait_for_idle();
            end
            random_item();
         end
      end
      stalls_on = 1'b1;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_PRIME;
      req_raw_core    = '0;
      req_raw_plane   = '0;
      req_raw_package = '0;
      req_raw_dram    = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_MASK;
      csr_data        = '0;
      for (int d = 0; d < LANES; d++) begin
         last_count[d]   = '0;
         energy_total[d] = '0;
      end
      model_mask       = MASK_RESET;
      model_unit_shift = UNIT_SHIFT_RESET;
      model_dram_shift = DRAM_SHIFT_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_csr_extremes();
      test_scale_overflow();
      test_random_traffic();

      wait_for_idle();
      repeat (PIPE_LATENCY * 4) @(negedge clock);
      if (error_count == 0 && expected_energy_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
